// ===== rtl/rrlt_pkg.sv =====
// rrlt_pkg: command codes and shared types for the row range list translator
// used by rrlt_range_mem, row_range_list_translator and rrlt_checker
package rrlt_pkg;

  localparam int CMD_W   = 2;
  localparam int DATA_W  = 32;
  localparam int USED_W  = 9;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  typedef struct packed {
    logic first_en;
    logic last_en;
  } wr_en_t;

endpackage

// ===== rtl/rrlt_range_mem.sv =====
// rrlt_range_mem: range table storage, first and last row of each range
// one write port, one read port with registered data; depends on rrlt_pkg
module rrlt_range_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic            clk,
  input  rrlt_pkg::wr_en_t wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [DW-1:0]   wr_data,
  input  logic [AW-1:0]   rd_addr,
  output logic [DW-1:0]   rd_first,
  output logic [DW-1:0]   rd_last
);
  import rrlt_pkg::*;

  logic [DW-1:0] first_mem [DEPTH];
  logic [DW-1:0] last_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.first_en) begin
      first_mem[wr_addr] <= wr_data;
    end
    if (wr_en.last_en) begin
      last_mem[wr_addr] <= wr_data;
    end
    rd_first <= first_mem[rd_addr];
    rd_last  <= last_mem[rd_addr];
  end

endmodule

// ===== rtl/row_range_list_translator.sv =====
// row_range_list_translator: builds a table of contiguous row ranges and maps
// display positions to actual rows; depends on rrlt_pkg and rrlt_range_mem
//
// Usage
//   request channel: in_valid / in_stall with cmd, row_index, display_pos
//   result channel: out_valid / out_stall with mapped_row, found, overflow,
//   ranges_used; exactly one result per request, in request order
//   config channel: cfg_valid / cfg_ready with cfg_data, writes the row limit;
//   cfg_ready is always high, write only while the block is idle
// Sequencing and throughput
//   append, clear, unused codes, and lookup with an empty table: result goes
//   to the output register, or parks if the receiver stalls; one request per
//   cycle while results are taken; other lookups walk k ranges (1 to
//   MAX_RANGES), one per cycle from the table's single read port, until a
//   range holds the position or the last range is passed
//   in_stall is high while a lookup walks or a finished result waits
// Reset
//   range table empty, row limit zero, no result pending; table contents
//   need no clearing since only entries below the range count are used
// Receiver stall
//   the output register holds its result; one further request may be taken,
//   its result then parks internally and in_stall stays high until delivered
module row_range_list_translator #(
  parameter int MAX_RANGES = 256,
  parameter int ROW_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rrlt_pkg::CMD_W-1:0]    cmd,
  input  logic [rrlt_pkg::DATA_W-1:0]   row_index,
  input  logic [rrlt_pkg::DATA_W-1:0]   display_pos,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrlt_pkg::DATA_W-1:0]   mapped_row,
  output logic                          found,
  output logic                          overflow,
  output logic [rrlt_pkg::USED_W-1:0]   ranges_used,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrlt_pkg::DATA_W-1:0]   cfg_data
);
  import rrlt_pkg::*;

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int CW    = (ROW_BITS > DATA_W) ? ROW_BITS : DATA_W;

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    HOLD
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [ROW_BITS-1:0]  tail_last;
  logic [DATA_W-1:0]    row_limit;
  logic [DATA_W-1:0]    rem;
  logic [IDX_W-1:0]     walk_idx;

  logic [DATA_W-1:0]    pend_row;
  logic                 pend_found;
  logic                 pend_ovf;
  logic [USED_W-1:0]    pend_used;

  logic                 in_accept;
  logic                 slot_free;
  logic [ROW_BITS-1:0]  row_in;
  logic                 can_extend;
  logic                 full;
  logic [ROW_BITS-1:0]  rd_first;
  logic [ROW_BITS-1:0]  rd_last;
  logic [ROW_BITS-1:0]  span;
  logic [ROW_BITS-1:0]  hit_row;
  logic                 hit;
  logic                 last_step;

  wr_en_t               wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [IDX_W-1:0]     rd_addr;

  logic                 fin;
  logic [DATA_W-1:0]    fin_row;
  logic                 fin_found;
  logic                 fin_ovf;
  logic [CNT_W-1:0]     count_next;
  logic [ROW_BITS-1:0]  tail_last_next;
  logic                 walk_start;

  assign in_stall  = (state != IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      row_limit <= cfg_data;
    end
  end

  rrlt_range_mem #(
    .DEPTH (MAX_RANGES),
    .AW    (IDX_W),
    .DW    (ROW_BITS)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (row_in),
    .rd_addr  (rd_addr),
    .rd_first (rd_first),
    .rd_last  (rd_last)
  );

  always_comb begin
    row_in     = ROW_BITS'(row_index);
    full       = (count == CNT_W'(MAX_RANGES));
    can_extend = (count != '0) && (tail_last != '1) &&
                 (row_in == tail_last + ROW_BITS'(1));
    span       = rd_last - rd_first;
    hit        = CW'(rem) <= CW'(span);
    hit_row    = rd_first + ROW_BITS'(rem);
    last_step  = (walk_idx == IDX_W'(count - CNT_W'(1)));

    wr_en          = '0;
    wr_addr        = IDX_W'(count);
    rd_addr        = IDX_W'(walk_idx + IDX_W'(1));
    fin            = 1'b0;
    fin_row        = '0;
    fin_found      = 1'b0;
    fin_ovf        = 1'b0;
    count_next     = count;
    tail_last_next = tail_last;
    walk_start     = 1'b0;

    case (state)
      IDLE: begin
        rd_addr = '0;
        if (in_accept) begin
          fin = 1'b1;
          case (cmd)
            CMD_APPEND: begin
              if (can_extend) begin
                wr_en.last_en  = 1'b1;
                wr_addr        = IDX_W'(count - CNT_W'(1));
                tail_last_next = row_in;
              end else if (full) begin
                fin_ovf = 1'b1;
              end else begin
                wr_en.first_en = 1'b1;
                wr_en.last_en  = 1'b1;
                tail_last_next = row_in;
                count_next     = count + CNT_W'(1);
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
            end
            CMD_LOOKUP: begin
              if (count == '0) begin
                if (display_pos < row_limit) begin
                  fin_found = 1'b1;
                  fin_row   = display_pos;
                end
              end else begin
                fin        = 1'b0;
                walk_start = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      WALK: begin
        if (hit) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_row   = DATA_W'(hit_row);
        end else if (last_step) begin
          fin = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      count     <= count_next;
      tail_last <= tail_last_next;
      if (walk_start) begin
        rem      <= display_pos;
        walk_idx <= '0;
        state    <= WALK;
      end else if (state == WALK && !fin) begin
        rem      <= rem - DATA_W'(span) - DATA_W'(1);
        walk_idx <= IDX_W'(walk_idx + IDX_W'(1));
      end
      if (fin) begin
        if (slot_free) begin
          out_valid   <= 1'b1;
          mapped_row  <= fin_row;
          found       <= fin_found;
          overflow    <= fin_ovf;
          ranges_used <= USED_W'(count_next);
          state       <= IDLE;
        end else begin
          pend_row    <= fin_row;
          pend_found  <= fin_found;
          pend_ovf    <= fin_ovf;
          pend_used   <= USED_W'(count_next);
          state       <= HOLD;
        end
      end else if (state == HOLD && slot_free) begin
        out_valid   <= 1'b1;
        mapped_row  <= pend_row;
        found       <= pend_found;
        overflow    <= pend_ovf;
        ranges_used <= pend_used;
        state       <= IDLE;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rrlt_checker.sv =====
// rrlt_checker: port level checks for row_range_list_translator
// bound to the top level below; depends on rrlt_pkg
module rrlt_checker #(
  parameter int MAX_RANGES = 256
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rrlt_pkg::DATA_W-1:0]   mapped_row,
  input logic                          found,
  input logic                          overflow,
  input logic [rrlt_pkg::USED_W-1:0]   ranges_used
);
  import rrlt_pkg::*;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && overflow))
    else $error("found and overflow both set");

  a_miss_zero_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (mapped_row == '0))
    else $error("mapped_row not zero without found");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (ranges_used == USED_W'(MAX_RANGES)))
    else $error("overflow reported with table not full");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(mapped_row) &&
                                  $stable(ranges_used)))
    else $error("stalled result changed");

endmodule

bind row_range_list_translator rrlt_checker #(
  .MAX_RANGES (MAX_RANGES)
) u_rrlt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .mapped_row  (mapped_row),
  .found       (found),
  .overflow    (overflow),
  .ranges_used (ranges_used)
);
